// File: src/srf_pkg.sv
`default_nettype none
package srf_pkg;
  localparam int SampleDepth = 64;
  localparam int AddrW = $clog2(SampleDepth);
  localparam int LenW = 7;
  localparam int SumW = 32 + AddrW + 2;

  localparam logic [1:0] ModeLimit = 2'd0;
  localparam logic [1:0] ModeMedian = 2'd1;

  localparam logic [2:0] RegMode = 3'd0;
  localparam logic [2:0] RegStep = 3'd1;
  localparam logic [2:0] RegStale = 3'd2;
  localparam logic [2:0] RegMedLen = 3'd3;
  localparam logic [2:0] RegWinLen = 3'd4;
endpackage
`default_nettype wire

// File: src/srf_divider.sv
`default_nettype none
// Restoring signed division, one quotient bit per cycle, truncating toward zero.
module srf_divider (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic signed [srf_pkg::SumW-1:0] dividend,
  input  wire logic [srf_pkg::LenW-1:0]    divisor,
  output logic                             done,
  output logic [31:0]                      quotient
);
  localparam int W = srf_pkg::SumW;
  logic [W-1:0] num;
  logic [W-1:0] quo;
  logic [W:0]   rem;
  logic [W:0]   trial;
  logic [srf_pkg::LenW-1:0] dv;
  logic         neg;
  logic         busy;
  logic [$clog2(W+1)-1:0] cnt;

  assign trial = {rem[W-1:0], num[W-1]} - (W+1)'(dv);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        neg  <= dividend[W-1];
        num  <= dividend[W-1] ? -dividend : dividend;
        dv   <= divisor;
        rem  <= '0;
        quo  <= '0;
        cnt  <= ($clog2(W+1))'(W);
      end else if (busy) begin
        // shift one dividend bit in, subtract if it fits
        if (!trial[W]) begin
          rem <= trial;
          quo <= {quo[W-2:0], 1'b1};
        end else begin
          rem <= {rem[W-1:0], num[W-1]};
          quo <= {quo[W-2:0], 1'b0};
        end
        num <= {num[W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == 1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? 32'(-quo) : quo[31:0];
endmodule
`default_nettype wire

// File: src/selectable_range_filter_unit.sv
`default_nettype none
// Result valid: in limit mode after a registered read of the held value; median
// on the sample that completes a group (insertion sort in the sample memory),
// no result otherwise; trimmed mean after the window sum, trim and divide, with a
// write position past the window first reduced modulo the window length.
// One transaction at a time; in_ready returns the cycle after out_ready takes the result.
// Reset: synchronous; a clearing pass zeroes all 64 sample memory entries, no input taken.
module selectable_range_filter_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [30:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] sample,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      filtered
);
  localparam int AW = srf_pkg::AddrW;
  localparam int D = srf_pkg::SampleDepth;
  localparam int LW = srf_pkg::LenW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LIM_RD, S_LIM_EV, S_MED_SORT_I, S_MED_RDJ,
    S_MED_CMP, S_MED_EMIT, S_MED_OUT, S_TM_MOD, S_TM_RD, S_TM_ACC, S_TM_DIV, S_OUT
  } state_t;

  logic [1:0]  mode;
  logic [30:0] limit_step;
  logic [15:0] stale_limit;
  logic [LW-1:0] median_len;
  logic [LW-1:0] window_len;

  logic signed [31:0] mem [D];
  logic signed [31:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic signed [31:0] wr_data;

  state_t state;
  logic [AW:0]   clr_cnt;
  logic [AW-1:0] write_pos;
  logic          started;
  logic [15:0]   reject_count;
  logic signed [31:0] s;
  logic signed [31:0] key;
  logic [AW:0]   i, j, len;
  logic signed [srf_pkg::SumW-1:0] sum;
  logic signed [31:0] lo, hi;
  logic          div_start, div_done;
  logic [31:0]   quot;
  logic signed [32:0] diff;
  logic [32:0]   adiff;

  // clamped lengths
  logic [AW:0] mlen, wlen;
  always_comb begin
    if (median_len == 0) mlen = (AW+1)'(1);
    else if (median_len > LW'(D)) mlen = (AW+1)'(D);
    else mlen = median_len[AW:0];
    if (window_len < LW'(3)) wlen = (AW+1)'(3);
    else if (window_len > LW'(D)) wlen = (AW+1)'(D);
    else wlen = window_len[AW:0];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 2'd2;
      limit_step <= 31'd5243;
      stale_limit <= 16'd100;
      median_len <= LW'(5);
      window_len <= LW'(50);
    end else if (cfg_we) begin
      case (cfg_index)
        srf_pkg::RegMode: mode <= cfg_data[1:0];
        srf_pkg::RegStep: limit_step <= cfg_data;
        srf_pkg::RegStale: stale_limit <= cfg_data[15:0];
        srf_pkg::RegMedLen: median_len <= cfg_data[LW-1:0];
        srf_pkg::RegWinLen: window_len <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  // sample memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  assign in_ready = (state == S_IDLE);
  assign diff = 33'(s) - 33'(rd_data);
  assign adiff = diff[32] ? 33'(-diff) : 33'(diff);

  srf_divider u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(sum), .divisor(LW'(wlen) - LW'(2)),
    .done(div_done), .quotient(quot)
  );

  always_comb begin
    wr_en = 1'b0;
    wr_addr = '0;
    wr_data = s;
    rd_addr = '0;
    div_start = 1'b0;
    case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = clr_cnt[AW-1:0];
        wr_data = '0;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (mode == srf_pkg::ModeLimit) begin
            rd_addr = '0;
            if (!started || reject_count > stale_limit) begin
              wr_en = 1'b1;
              wr_addr = '0;
              wr_data = sample;
            end
          end else if (mode == srf_pkg::ModeMedian) begin
            wr_en = 1'b1;
            wr_addr = write_pos;
            wr_data = sample;
          end
        end
      end
      S_LIM_EV: begin
        if (!(adiff > 33'(limit_step))) begin
          wr_en = 1'b1;
          wr_addr = '0;
          wr_data = s;
        end
      end
      S_MED_SORT_I: rd_addr = i[AW-1:0];
      S_MED_RDJ: rd_addr = AW'(j - 1'b1);
      S_MED_CMP: begin
        // shift larger entry up, or drop key into place
        wr_en = 1'b1;
        if (j != 0 && rd_data > key) begin
          wr_addr = j[AW-1:0];
          wr_data = rd_data;
          rd_addr = AW'(j - 2'd2);
        end else begin
          wr_addr = j[AW-1:0];
          wr_data = key;
        end
      end
      S_MED_EMIT: rd_addr = AW'((len - 1'b1) >> 1);
      S_TM_MOD: begin
        // store once the position lies inside the window
        if (!((AW+1)'(write_pos) >= len)) begin
          wr_en = 1'b1;
          wr_addr = write_pos;
          wr_data = s;
        end
      end
      S_TM_RD: rd_addr = '0;
      S_TM_ACC: rd_addr = AW'(i + 1'b1);
      S_TM_DIV: div_start = (i == (AW+1)'(1));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      write_pos <= '0;
      started <= 1'b0;
      reject_count <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AW+1)'(D-1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            s <= sample;
            if (mode == srf_pkg::ModeLimit) begin
              started <= 1'b1;
              state <= S_LIM_RD;
            end else if (mode == srf_pkg::ModeMedian) begin
              len <= mlen;
              if ((AW+1)'(write_pos) + 1'b1 >= mlen) begin
                write_pos <= '0;
                i <= (AW+1)'(1);
                state <= S_MED_SORT_I;
              end else begin
                write_pos <= write_pos + 1'b1;
              end
            end else begin
              len <= wlen;
              i <= '0;
              sum <= '0;
              state <= S_TM_MOD;
            end
          end
        end
        S_LIM_RD: state <= S_LIM_EV;
        S_LIM_EV: begin
          if (adiff > 33'(limit_step)) begin
            if (reject_count != 16'hFFFF) reject_count <= reject_count + 1'b1;
            filtered <= rd_data;
          end else begin
            reject_count <= '0;
            filtered <= s;
          end
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_MED_SORT_I: begin
          if (i >= len) state <= S_MED_EMIT;
          else begin
            j <= i;
            state <= S_MED_RDJ;
          end
        end
        S_MED_RDJ: begin
          key <= rd_data;
          state <= S_MED_CMP;
        end
        S_MED_CMP: begin
          if (j != 0 && rd_data > key) begin
            j <= j - 1'b1;
            // read of j-2 already issued; if j-1 is 0 the compare stops anyway
          end else begin
            i <= i + 1'b1;
            state <= S_MED_SORT_I;
          end
        end
        S_MED_EMIT: state <= S_MED_OUT;
        S_MED_OUT: begin
          filtered <= rd_data;
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_TM_MOD: begin
          // reduce the write position modulo the window length
          if ((AW+1)'(write_pos) >= len) begin
            write_pos <= AW'((AW+1)'(write_pos) - len);
          end else begin
            if ((AW+1)'(write_pos) + 1'b1 == len) write_pos <= '0;
            else write_pos <= write_pos + 1'b1;
            state <= S_TM_RD;
          end
        end
        S_TM_RD: state <= S_TM_ACC;
        S_TM_ACC: begin
          sum <= sum + srf_pkg::SumW'(rd_data);
          if (i == 0 || rd_data < lo) lo <= rd_data;
          if (i == 0 || rd_data > hi) hi <= rd_data;
          if (i + 1'b1 == len) begin
            i <= '0;
            state <= S_TM_DIV;
          end else i <= i + 1'b1;
        end
        S_TM_DIV: begin
          // trim the extremes, then start the divide on the trimmed sum
          if (i == 0) begin
            i <= (AW+1)'(1);
            sum <= sum - srf_pkg::SumW'(lo) - srf_pkg::SumW'(hi);
          end else if (i == (AW+1)'(1)) begin
            i <= (AW+1)'(2);
          end else if (div_done) begin
            filtered <= quot;
            out_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
